/* hw/rtl/keht_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keht_pkg
// Shared constants and types for the key edge and hold tracker.
// ----------------------------------------------------------------------------
package keht_pkg;

  // Size of the key table
  localparam int NUM_KEYS  = 256;
  localparam int KEY_IDX_W = $clog2(NUM_KEYS);

  // Field widths
  localparam int OPCODE_W = 3;
  localparam int KEY_W    = 8;
  localparam int TIME_W   = 32;

  // Item codes
  typedef enum logic [OPCODE_W-1:0] {
    OP_PRESS   = 3'd0,
    OP_RELEASE = 3'd1,
    OP_FRAME   = 3'd2,
    OP_TICK    = 3'd3,
    OP_QUERY   = 3'd4
  } opcode_t;

  typedef logic [KEY_IDX_W-1:0] key_idx_t;
  typedef logic [TIME_W-1:0]    time_t;

endpackage

/* hw/rtl/key_edge_and_hold_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_edge_and_hold_tracker
// Per-key down / edge / hold tracking with a millisecond counter advanced by ticks.
// ----------------------------------------------------------------------------
// Every input transaction (press, release, frame end, tick or query) yields
// exactly one result transaction; only a query gives non-zero fields. One
// transaction is taken per clock while in_stall is low. The key table updates
// at acceptance, and the event time memory is read through its registered read
// ports in the same cycle into the lookup stage; the result then passes from the
// lookup stage to the result register once the output is not stalled; the time
// subtract and compares run between those two. The key state bits and the
// event time valid bits are flip-flops cleared by reset, so no clearing pass
// is needed and the block takes transactions right after reset.
module key_edge_and_hold_tracker (
  input  logic                       clk,
  input  logic                       rst,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [keht_pkg::OPCODE_W-1:0] opcode,
  input  logic [keht_pkg::KEY_W-1:0] key,
  input  logic [keht_pkg::KEY_W-1:0] other_key,
  input  logic [keht_pkg::TIME_W-1:0] hold_ms,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       is_down,
  output logic                       is_toggled,
  output logic                       is_hit,
  output logic                       is_released,
  output logic                       held_long,
  output logic                       pressed_before_other,
  output logic [keht_pkg::TIME_W-1:0] rest_ms
);
  import keht_pkg::*;

  // Key table state
  time_t                now_ms;
  logic [NUM_KEYS-1:0]  down_bits;
  logic [NUM_KEYS-1:0]  prior_bits;
  logic [NUM_KEYS-1:0]  frame_event_bits;
  logic [NUM_KEYS-1:0]  time_valid;
  time_t                event_time [NUM_KEYS];

  // Lookup stage registers
  logic   s1_valid;
  logic   s1_query;
  logic   s1_dn;
  logic   s1_tg;
  logic   s1_dn2;
  logic   s1_tv1;
  logic   s1_tv2;
  time_t  s1_now;
  time_t  s1_hold;
  time_t  rd_time1;
  time_t  rd_time2;

  // Handshake
  logic out_adv;
  logic s1_adv;
  logic in_acc;

  assign out_adv  = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_adv;
  assign in_stall = s1_valid && !out_adv;
  assign in_acc   = in_valid && !in_stall;

  // Decode of the incoming transaction
  opcode_t  op;
  logic     key_ok;
  logic     key2_ok;
  key_idx_t kidx;
  key_idx_t k2idx;
  logic     is_event;

  assign op       = opcode_t'(opcode);
  assign key_ok   = 32'(key) < NUM_KEYS;
  assign key2_ok  = 32'(other_key) < NUM_KEYS;
  assign kidx     = KEY_IDX_W'(key);
  assign k2idx    = KEY_IDX_W'(other_key);
  assign is_event = (op == OP_PRESS) || (op == OP_RELEASE);

  // Key state bits, time counter and lookup stage
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms           <= '0;
      down_bits        <= '0;
      prior_bits       <= '0;
      frame_event_bits <= '0;
      time_valid       <= '0;
      s1_valid         <= 1'b0;
    end else begin
      if (in_acc) begin
        case (op)
          OP_PRESS, OP_RELEASE: begin
            if (key_ok) begin
              prior_bits[kidx]       <= down_bits[kidx];
              down_bits[kidx]        <= (op == OP_PRESS);
              frame_event_bits[kidx] <= 1'b1;
              time_valid[kidx]       <= 1'b1;
            end
          end
          OP_FRAME: frame_event_bits <= '0;
          OP_TICK:  now_ms <= now_ms + 1'b1;
          default: ;
        endcase
      end
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Lookup payload: snapshot of the key bits, taken with the transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_query <= (op == OP_QUERY);
      s1_dn    <= key_ok && down_bits[kidx];
      s1_tg    <= key_ok && frame_event_bits[kidx] &&
                  (down_bits[kidx] != prior_bits[kidx]);
      s1_dn2   <= key2_ok && down_bits[k2idx];
      s1_tv1   <= key_ok && time_valid[kidx];
      s1_tv2   <= key2_ok && time_valid[k2idx];
      s1_now   <= now_ms;
      s1_hold  <= hold_ms;
    end
  end

  // Event time memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (in_acc && is_event && key_ok) begin
      event_time[kidx] <= now_ms;
    end
    if (in_acc) begin
      rd_time1 <= event_time[kidx];
      rd_time2 <= event_time[k2idx];
    end
  end

  // Query evaluation
  time_t t1;
  time_t t2;
  time_t rest;
  logic  q_dn;
  logic  q_tg;

  assign t1   = s1_tv1 ? rd_time1 : '0;
  assign t2   = s1_tv2 ? rd_time2 : '0;
  assign rest = s1_now - t1;
  assign q_dn = s1_query && s1_dn;
  assign q_tg = s1_query && s1_tg;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      is_down              <= q_dn;
      is_toggled           <= q_tg;
      is_hit               <= q_dn && q_tg;
      is_released          <= !q_dn && q_tg;
      held_long            <= q_dn && (rest >= s1_hold);
      pressed_before_other <= q_dn && s1_dn2 && (t1 < t2);
      rest_ms              <= s1_query ? rest : '0;
    end
  end

`ifndef SYNTH
  // Nothing is held back unless the lookup stage is occupied
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty lookup stage");

  // A blocked lookup stage keeps its transaction
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid)
    else $error("lookup stage dropped a transaction");

  // A tick advances the time counter by one
  a_tick: assert property (@(posedge clk) disable iff (rst)
    in_acc && (op == OP_TICK) |=> now_ms == $past(now_ms) + 32'd1)
    else $error("tick did not advance time");

  // Time counter starts from zero
  a_reset_time: assert property (@(posedge clk)
    $past(rst) |-> now_ms == '0)
    else $error("time not cleared by reset");

  // Flags that need the key down stay low for a key that is up
  a_up_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_down |-> !is_hit && !held_long && !pressed_before_other)
    else $error("down-only flag set for a key that is up");
`endif

endmodule
